/* rtl/core/ajtd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ajtd_pkg;

  // Request codes carried by in_req_type
  typedef enum logic [1:0] {
    REQ_SAMPLE    = 2'd0,
    REQ_ARM       = 2'd1,
    REQ_TAP_READ  = 2'd2,
    REQ_PEAK_READ = 2'd3
  } req_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TAP_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIN_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_SETTLE_TIME   = 2'd2;
  localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd3;

  // Register reset values
  localparam logic [15:0] TAP_THRESHOLD_RST = 16'd6144;
  localparam logic [15:0] MIN_THRESHOLD_RST = 16'd1229;
  localparam logic [15:0] SETTLE_TIME_RST   = 16'd500;
  localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd300;

  // Magnitude constants, 4096 LSB per g
  localparam logic [15:0] ONE_G_LSB = 16'd4096;
  localparam logic [15:0] MAG_MAX   = 16'hFFFF;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_idx;
    logic       root_step;
    logic       finish;
  } ajtd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_sample;
    logic out_free;
  } ajtd_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ajtd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ajtd_ctrl import ajtd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ajtd_stat_t stat,
  output ajtd_cmd_t       cmd
);

  localparam int CNT_W = $clog2(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(SAMPLE_BITS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Sequencer: square-and-add, one root bit a cycle, then commit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stat.in_is_sample ? ST_SQUARE : ST_FINISH;
        end
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        cmd.sq_idx  = cnt_r[1:0];
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ajtd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ajtd_dp import ajtd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ajtd_cmd_t                     cmd,
  output ajtd_stat_t                         stat,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  wire logic [31:0]                   in_now_ms,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_tap_detected,
  output logic                               out_tap_read,
  output logic [15:0]                        out_peak_value,
  output logic [15:0]                        out_jerk
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SUM_W = 2 * SB;
  localparam int REM_W = SB + 3;
  localparam int MAG_W = (SB > 16) ? SB : 16;

  function automatic logic [SB-1:0] abs_s(input logic signed [SB-1:0] v);
    abs_s = v[SB-1] ? (~$unsigned(v)) + 1'b1 : $unsigned(v);
  endfunction

  // configuration
  logic [15:0] tap_thr_r, min_thr_r, settle_r, debounce_r;

  // captured beat
  req_t          req_r;
  logic [SB-1:0] ax_r, ay_r, az_r;
  logic [31:0]   now_r;

  // square-and-add, root
  logic [SUM_W-1:0] prod_r, acc_r, rad_r;
  logic [REM_W-1:0] rem_r;
  logic [SB-1:0]    root_r;

  // detector state
  logic [15:0] prev_mag_r, peak_r;
  logic [31:0] last_tap_r, arm_time_r;
  logic        pending_r;

  // result register
  logic        out_valid_r, out_tap_detected_r, out_tap_read_r;
  logic [15:0] out_peak_value_r, out_jerk_r;

  assign stat.in_is_sample = (req_t'(in_req_type) == REQ_SAMPLE);
  assign stat.out_free     = !out_valid_r || out_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_thr_r  <= TAP_THRESHOLD_RST;
      min_thr_r  <= MIN_THRESHOLD_RST;
      settle_r   <= SETTLE_TIME_RST;
      debounce_r <= DEBOUNCE_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_THRESHOLD: tap_thr_r  <= cfg_wdata;
        CFG_MIN_THRESHOLD: min_thr_r  <= cfg_wdata;
        CFG_SETTLE_TIME:   settle_r   <= cfg_wdata;
        CFG_DEBOUNCE_TIME: debounce_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared squarer operand
  logic [SB-1:0] sq_op;
  always_comb begin
    unique case (cmd.sq_idx)
      2'd0:    sq_op = ax_r;
      2'd1:    sq_op = ay_r;
      2'd2:    sq_op = az_r;
      default: sq_op = '0;
    endcase
  end

  // one root bit: bring down two radicand bits, trial-subtract
  logic [REM_W-1:0] rem_sh, trial;
  logic             root_ge;
  assign rem_sh  = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign root_ge = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      ax_r  <= abs_s(in_accel_x);
      ay_r  <= abs_s(in_accel_y);
      az_r  <= abs_s(in_accel_z);
      now_r <= in_now_ms;
      acc_r <= '0;
    end
    if (cmd.sq_step) begin
      if (cmd.sq_idx != 2'd3) prod_r <= sq_op * sq_op;
      if (cmd.sq_idx != 2'd0) acc_r  <= acc_r + prod_r;
      if (cmd.sq_idx == 2'd3) begin
        rad_r  <= acc_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
      end
    end
    if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= root_ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[SB-2:0], root_ge};
    end
  end

  // tap decision on the finished magnitude
  logic [MAG_W-1:0] root_ext;
  logic [15:0]      mag_val, jerk_val, thr_val;
  logic [31:0]      since_arm, since_tap;
  logic             tap_hit;
  always_comb begin
    root_ext  = MAG_W'(root_r);
    mag_val   = (root_ext > MAG_W'(MAG_MAX)) ? MAG_MAX : root_ext[15:0];
    jerk_val  = (mag_val >= prev_mag_r) ? mag_val - prev_mag_r : prev_mag_r - mag_val;
    thr_val   = (tap_thr_r < min_thr_r) ? min_thr_r : tap_thr_r;
    since_arm = now_r - arm_time_r;
    since_tap = now_r - last_tap_r;
    tap_hit   = (since_arm >= {16'd0, settle_r}) && (jerk_val > thr_val) &&
                (since_tap > {16'd0, debounce_r});
  end

  // detector state update at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r <= ONE_G_LSB;
      last_tap_r <= '0;
      arm_time_r <= '0;
      pending_r  <= 1'b0;
      peak_r     <= '0;
    end else if (cmd.finish) begin
      unique case (req_r)
        REQ_SAMPLE: begin
          prev_mag_r <= mag_val;
          if (jerk_val > peak_r) peak_r <= jerk_val;
          if (tap_hit) begin
            last_tap_r <= now_r;
            pending_r  <= 1'b1;
          end
        end
        REQ_ARM: begin
          arm_time_r <= now_r;
          prev_mag_r <= ONE_G_LSB;
          pending_r  <= 1'b0;
        end
        REQ_TAP_READ:  pending_r <= 1'b0;
        REQ_PEAK_READ: peak_r    <= '0;
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_tap_detected_r <= (req_r == REQ_SAMPLE) && tap_hit;
      out_jerk_r         <= (req_r == REQ_SAMPLE) ? jerk_val : 16'd0;
      out_tap_read_r     <= (req_r == REQ_TAP_READ) && pending_r;
      out_peak_value_r   <= (req_r == REQ_PEAK_READ) ? peak_r : 16'd0;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tap_detected = out_tap_detected_r;
  assign out_tap_read     = out_tap_read_r;
  assign out_peak_value   = out_peak_value_r;
  assign out_jerk         = out_jerk_r;

endmodule

`default_nettype wire

/* rtl/core/accel_jerk_tap_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// Accelerometer jerk tap detector.
// Input channel (in_valid/in_ready): one request per beat, in_req_type selects
// sample, arm, tap read-and-clear or peak read-and-clear. Result channel
// (out_valid/out_ready): exactly one result beat per request, unused fields 0.
// Configuration: cfg_we with cfg_index/cfg_wdata writes a threshold or time
// register; write only while no request is in flight.
// Flow: a sample passes through one shared squarer and adder, then resolves
// one square-root bit per cycle, then commits; other requests go straight
// to commit. out_valid is registered at commit.
// One request is in flight at a time; in_ready is high whenever the
// sequencer is idle, so the next request is taken while a result waits.
// A stalled receiver holds the result register; a request that finishes
// behind it waits in its commit cycle until the result register frees.
// Reset (rst_n, synchronous, active low) restores register defaults,
// previous magnitude to 1 g, clears pending tap, peak and time stamps.
module accel_jerk_tap_detector import ajtd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  wire logic [31:0]                   in_now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_tap_detected,
  output logic                               out_tap_read,
  output logic [15:0]                        out_peak_value,
  output logic [15:0]                        out_jerk,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_wdata
);

  ajtd_cmd_t  cmd;
  ajtd_stat_t stat;

  // sequencer
  ajtd_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, detector state and result register
  ajtd_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_req_type),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .in_now_ms        (in_now_ms),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tap_detected (out_tap_detected),
    .out_tap_read     (out_tap_read),
    .out_peak_value   (out_peak_value),
    .out_jerk         (out_jerk)
  );

endmodule

`default_nettype wire

/* rtl/core/ajtd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ajtd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_tap_detected,
  input wire logic        out_tap_read,
  input wire logic [15:0] out_peak_value,
  input wire logic [15:0] out_jerk
);

  // one request in flight: a taken beat drops ready next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted beat");

  // a tap read result carries nothing but the tap flag
  a_tap_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tap_read |->
      !out_tap_detected && out_jerk == 16'd0 && out_peak_value == 16'd0)
    else $error("tap read result carries sample or peak fields");

  // a tap is only raised by a sample, which carries no peak
  a_tap_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tap_detected |-> out_peak_value == 16'd0 && out_jerk != 16'd0)
    else $error("tap flagged on a non-sample result");

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_jerk) &&
      $stable(out_peak_value) && $stable(out_tap_detected) && $stable(out_tap_read))
    else $error("result beat changed while stalled");

endmodule

bind accel_jerk_tap_detector ajtd_checker u_ajtd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_tap_detected (out_tap_detected),
  .out_tap_read     (out_tap_read),
  .out_peak_value   (out_peak_value),
  .out_jerk         (out_jerk)
);

`default_nettype wire
